>>> rtl/core/ntcbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ntcbt_pkg;

    typedef struct packed {
        logic       ok;
        logic [1:0] ch;
    } t_side;

    typedef enum logic [1:0] {
        CFG_SETPOINT = 2'd0,
        CFG_KP       = 2'd1,
        CFG_BIAS     = 2'd2,
        CFG_MAX      = 2'd3
    } t_cfg_idx;

    localparam int LogSteps = 28;
    localparam int DivSteps = 28;

    localparam logic [14:0] AdcFull    = 15'd24000;
    localparam logic [29:0] Ln2Q30     = 30'd744261118;
    localparam logic [18:0] BetaX100   = 19'd395000;
    localparam logic [15:0] T0X100     = 16'd29815;
    localparam logic [44:0] DivRemInit = 45'd482382848000;
    localparam logic [31:0] ZeroCQ16X5 = 32'd89505792;

    localparam logic signed [16:0] SetpointReset = 17'sd4608;
    localparam logic [15:0]        KpReset       = 16'd10483;
    localparam logic [11:0]        BiasReset     = 12'd614;
    localparam logic [11:0]        MaxReset      = 12'd1228;

    function automatic logic [3:0] msb_pos(input logic [14:0] a);
        logic [3:0] p;
        p = '0;
        for (int i = 0; i < 15; i++) begin
            if (a[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    // One squaring step of the bit-by-bit logarithm: flag bit then new mantissa.
    function automatic logic [31:0] sq_step(input logic [30:0] m);
        logic [61:0] p;
        logic [31:0] s;
        p = 62'(m) * 62'(m);
        s = p[61:30];
        if (s[31]) begin
            return {1'b1, s[31:1]};
        end
        return {1'b0, s[30:0]};
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ntcbt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ntcbt_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  channel;
    logic signed [15:0] adc_code;
    modport source (output valid, channel, adc_code, input ready);
    modport sink (input valid, channel, adc_code, output ready);
endinterface

interface ntcbt_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  channel_out;
    logic               temp_valid;
    logic signed [16:0] temperature;
    logic               dac_update;
    logic        [11:0] dac_code;
    modport source (output valid, channel_out, temp_valid, temperature, dac_update,
                    dac_code, input ready);
    modport sink (input valid, channel_out, temp_valid, temperature, dac_update,
                  dac_code, output ready);
endinterface

interface ntcbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ntc_beta_temp_to_dac_p_control.sv
`timescale 1ns / 1ps
`default_nettype none
// Depth: 66 register stages from the input register to the offered result.
// Throughput: one item per cycle unless the output stalls; the 28-step logarithm
// squaring chain and the 28-step restoring divider are fully pipelined, so neither
// repeats on an item. A stall at the output holds every stage in place.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration registers with their reset values.
module ntc_beta_temp_to_dac_p_control #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ntcbt_in_if.sink   i_in,
    ntcbt_out_if.source o_out,
    ntcbt_cfg_if.sink  i_cfg
);
    import ntcbt_pkg::*;

    logic               w_en;
    logic               r_vld;
    t_side              r_side;
    logic [14:0]        r_a;
    logic [14:0]        r_b;
    logic signed [16:0] r_setpoint;
    logic [15:0]        r_kp;
    logic [11:0]        r_bias;
    logic [11:0]        r_max;

    logic               w_ok;
    logic               w_lvld, w_kvld, w_ovld;
    t_side              w_lside, w_kside;
    logic [31:0]        w_lg_a, w_lg_b;
    logic [27:0]        w_tk;
    logic [1:0]         w_ch;
    logic               w_tok;
    logic signed [16:0] w_temp;
    logic [11:0]        w_dac;

    assign w_en        = !w_ovld || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;
    assign w_ok = (32'(i_in.channel) < NUM_CHANNELS) && (i_in.adc_code > 16'sd0)
               && (i_in.adc_code < $signed({1'b0, AdcFull}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= SetpointReset;
            r_kp       <= KpReset;
            r_bias     <= BiasReset;
            r_max      <= MaxReset;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SETPOINT: r_setpoint <= $signed(i_cfg.data);
                CFG_KP:       r_kp       <= i_cfg.data[15:0];
                CFG_BIAS:     r_bias     <= i_cfg.data[11:0];
                CFG_MAX:      r_max      <= i_cfg.data[11:0];
                default:      r_max      <= r_max;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side.ch <= i_in.channel;
            r_side.ok <= w_ok;
            r_a       <= w_ok ? i_in.adc_code[14:0] : 15'd1;
            r_b       <= w_ok ? (AdcFull - i_in.adc_code[14:0]) : 15'd1;
        end
    end

    ntcbt_log2_pipe u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld),
        .i_side  (r_side),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_vld   (w_lvld),
        .o_side  (w_lside),
        .o_lg_a  (w_lg_a),
        .o_lg_b  (w_lg_b)
    );

    ntcbt_kelvin_pipe u_kelvin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_lvld),
        .i_side  (w_lside),
        .i_lg_a  (w_lg_a),
        .i_lg_b  (w_lg_b),
        .o_vld   (w_kvld),
        .o_side  (w_kside),
        .o_tk    (w_tk)
    );

    ntcbt_ctrl_pipe u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (w_kvld),
        .i_side     (w_kside),
        .i_tk       (w_tk),
        .i_setpoint (r_setpoint),
        .i_kp       (r_kp),
        .i_bias     (r_bias),
        .i_max      (r_max),
        .o_vld      (w_ovld),
        .o_ch       (w_ch),
        .o_ok       (w_tok),
        .o_temp     (w_temp),
        .o_dac      (w_dac)
    );

    assign o_out.valid       = w_ovld;
    assign o_out.channel_out = w_ch;
    assign o_out.temp_valid  = w_tok;
    assign o_out.temperature = w_temp;
    assign o_out.dac_update  = w_tok;
    assign o_out.dac_code    = w_dac;
endmodule
`default_nettype wire

>>> rtl/core/ntcbt_log2_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module ntcbt_log2_pipe (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire ntcbt_pkg::t_side i_side,
    input  wire logic [14:0]     i_a,
    input  wire logic [14:0]     i_b,
    output logic                 o_vld,
    output ntcbt_pkg::t_side     o_side,
    output logic [31:0]          o_lg_a,
    output logic [31:0]          o_lg_b
);
    import ntcbt_pkg::*;

    logic        r_vld  [0:LogSteps];
    t_side       r_side [0:LogSteps];
    logic [30:0] r_m_a  [0:LogSteps];
    logic [30:0] r_m_b  [0:LogSteps];
    logic [3:0]  r_e_a  [0:LogSteps];
    logic [3:0]  r_e_b  [0:LogSteps];
    logic [27:0] r_f_a  [0:LogSteps];
    logic [27:0] r_f_b  [0:LogSteps];
    logic [31:0] w_sq_a [1:LogSteps];
    logic [31:0] w_sq_b [1:LogSteps];
    logic [3:0]  w_e_a;
    logic [3:0]  w_e_b;

    always_comb begin
        w_e_a = msb_pos(i_a);
        w_e_b = msb_pos(i_b);
        for (int k = 1; k <= LogSteps; k++) begin
            w_sq_a[k] = sq_step(r_m_a[k-1]);
            w_sq_b[k] = sq_step(r_m_b[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LogSteps; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k <= LogSteps; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_e_a[0]  <= w_e_a;
            r_e_b[0]  <= w_e_b;
            r_m_a[0]  <= {16'b0, i_a} << (5'd30 - {1'b0, w_e_a});
            r_m_b[0]  <= {16'b0, i_b} << (5'd30 - {1'b0, w_e_b});
            r_f_a[0]  <= '0;
            r_f_b[0]  <= '0;
            for (int k = 1; k <= LogSteps; k++) begin
                r_side[k] <= r_side[k-1];
                r_e_a[k]  <= r_e_a[k-1];
                r_e_b[k]  <= r_e_b[k-1];
                r_m_a[k]  <= w_sq_a[k][30:0];
                r_m_b[k]  <= w_sq_b[k][30:0];
                r_f_a[k]  <= {r_f_a[k-1][26:0], w_sq_a[k][31]};
                r_f_b[k]  <= {r_f_b[k-1][26:0], w_sq_b[k][31]};
            end
        end
    end

    assign o_vld  = r_vld[LogSteps];
    assign o_side = r_side[LogSteps];
    assign o_lg_a = {r_e_a[LogSteps], r_f_a[LogSteps]};
    assign o_lg_b = {r_e_b[LogSteps], r_f_b[LogSteps]};
endmodule
`default_nettype wire

>>> rtl/core/ntcbt_kelvin_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module ntcbt_kelvin_pipe (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire ntcbt_pkg::t_side i_side,
    input  wire logic [31:0]     i_lg_a,
    input  wire logic [31:0]     i_lg_b,
    output logic                 o_vld,
    output ntcbt_pkg::t_side     o_side,
    output logic [27:0]          o_tk
);
    import ntcbt_pkg::*;

    logic               r_vld_a, r_vld_b, r_vld_c;
    t_side              r_side_a, r_side_b;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic signed [28:0] r_ln;

    logic        r_vld  [0:DivSteps];
    t_side       r_side [0:DivSteps];
    logic [43:0] r_den  [0:DivSteps];
    logic [44:0] r_rem  [0:DivSteps];
    logic [27:0] r_q    [0:DivSteps];

    logic signed [32:0] w_lg;
    logic [61:0]        w_prod;
    logic signed [28:0] w_ln;
    logic signed [45:0] w_den;
    logic [44:0]        w_sh   [1:DivSteps];
    logic               w_ge   [1:DivSteps];

    always_comb begin
        w_lg   = $signed({1'b0, i_lg_a}) - $signed({1'b0, i_lg_b});
        w_prod = 62'(r_mag) * 62'(Ln2Q30);
        w_ln   = r_neg ? (-$signed({1'b0, w_prod[61:34]}) - 29'sd1)
                       : $signed({1'b0, w_prod[61:34]});
        w_den  = $signed({3'b0, BetaX100, 24'b0})
               + 46'($signed({1'b0, T0X100}) * r_ln);
        if (w_den < 46'sd1) begin
            w_den = 46'sd1;
        end
        for (int k = 1; k <= DivSteps; k++) begin
            w_sh[k] = {r_rem[k-1][43:0], 1'b0};
            w_ge[k] = w_sh[k] >= {1'b0, r_den[k-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            for (int k = 0; k <= DivSteps; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld_a  <= i_vld;
            r_vld_b  <= r_vld_a;
            r_vld[0] <= r_vld_b;
            for (int k = 1; k <= DivSteps; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_a  <= i_side;
            r_neg     <= w_lg[32];
            r_mag     <= w_lg[32] ? 32'(-w_lg) : w_lg[31:0];
            r_side_b  <= r_side_a;
            r_ln      <= w_ln;
            r_side[0] <= r_side_b;
            r_den[0]  <= w_den[43:0];
            r_rem[0]  <= DivRemInit;
            r_q[0]    <= '0;
            for (int k = 1; k <= DivSteps; k++) begin
                r_side[k] <= r_side[k-1];
                r_den[k]  <= r_den[k-1];
                r_rem[k]  <= w_ge[k] ? (w_sh[k] - {1'b0, r_den[k-1]}) : w_sh[k];
                r_q[k]    <= {r_q[k-1][26:0], w_ge[k]};
            end
        end
    end

    assign r_vld_c = r_vld[DivSteps];
    assign o_vld   = r_vld_c;
    assign o_side  = r_side[DivSteps];
    assign o_tk    = r_q[DivSteps];
endmodule
`default_nettype wire

>>> rtl/core/ntcbt_ctrl_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module ntcbt_ctrl_pipe (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire ntcbt_pkg::t_side    i_side,
    input  wire logic [27:0]        i_tk,
    input  wire logic signed [16:0] i_setpoint,
    input  wire logic [15:0]        i_kp,
    input  wire logic [11:0]        i_bias,
    input  wire logic [11:0]        i_max,
    output logic                    o_vld,
    output logic [1:0]              o_ch,
    output logic                    o_ok,
    output logic signed [16:0]      o_temp,
    output logic [11:0]             o_dac
);
    import ntcbt_pkg::*;

    logic               r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    t_side              r_side1, r_side2, r_side3, r_side4;
    logic [17:0]        r_yo1, r_yo2;
    logic [15:0]        r_q0;
    logic signed [16:0] r_t3, r_t4;
    logic signed [34:0] r_prod;
    logic [1:0]         r_ch;
    logic               r_ok;
    logic signed [16:0] r_temp;
    logic [11:0]        r_dac;

    logic signed [33:0] w_t5;
    logic signed [25:0] w_y;
    logic signed [25:0] w_ysat;
    logic [31:0]        w_p;
    logic [17:0]        w_rem;
    logic [15:0]        w_q;
    logic signed [17:0] w_err;
    logic signed [18:0] w_sh;
    logic signed [19:0] w_d;
    logic [11:0]        w_dac;

    always_comb begin
        w_t5 = $signed({6'b0, i_tk}) * 34'sd5 - $signed({2'b0, ZeroCQ16X5});
        w_y  = 26'((w_t5 + 34'sd640) >>> 8);
        if (w_y < -26'sd51200) begin
            w_ysat = -26'sd51200;
        end else if (w_y > 26'sd192004) begin
            w_ysat = 26'sd192004;
        end else begin
            w_ysat = w_y;
        end
        w_p   = 32'(r_yo1) * 32'd13107;
        w_rem = r_yo2 - 18'(r_q0 * 16'd5);
        w_q   = (w_rem >= 18'd5) ? r_q0 + 16'd1 : r_q0;
        w_err = 18'(r_t3) - 18'(i_setpoint);
        w_sh  = 19'(r_prod >>> 16);
        w_d   = 20'(w_sh) + $signed({8'b0, i_bias});
        if (w_d < 20'sd0) begin
            w_dac = '0;
        end else if (w_d > $signed({8'b0, i_max})) begin
            w_dac = i_max;
        end else begin
            w_dac = w_d[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_yo1   <= 18'(w_ysat + 26'sd51200);
            r_side2 <= r_side1;
            r_yo2   <= r_yo1;
            r_q0    <= w_p[31:16];
            r_side3 <= r_side2;
            r_t3    <= $signed({1'b0, w_q}) - 17'sd10240;
            r_side4 <= r_side3;
            r_t4    <= r_t3;
            r_prod  <= $signed({2'b0, i_kp}) * 35'(w_err);
            r_ch    <= r_side4.ch;
            r_ok    <= r_side4.ok;
            r_temp  <= r_side4.ok ? r_t4 : '0;
            r_dac   <= r_side4.ok ? w_dac : '0;
        end
    end

    assign o_vld  = r_vld5;
    assign o_ch   = r_ch;
    assign o_ok   = r_ok;
    assign o_temp = r_temp;
    assign o_dac  = r_dac;
endmodule
`default_nettype wire
